>>> rtl/core/ile_pkg.sv
// Package: shared types and codes for the indexed list engine.
`default_nettype none
package ile_pkg;

    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int LENGTH_W = 7;

    typedef enum logic [FUNC_W-1:0] {
        OP_READ   = 3'd0,
        OP_FRONT  = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_DELETE = 3'd4
    } op_t;

    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/ile_cell.sv
// One list slot: holds a value, shifts with its neighbors on insert or delete.
`default_nettype none
module ile_cell #(
    parameter int IDX_W = 7,
    parameter int INDEX = 0
) (
    input  wire                       aclk,
    input  ile_pkg::cell_ctl_t        ctl,
    input  wire  [IDX_W-1:0]          tgt_pos,
    input  wire  [ile_pkg::DATA_W-1:0] ins_value,
    input  wire  [ile_pkg::DATA_W-1:0] prev_value,
    input  wire  [ile_pkg::DATA_W-1:0] next_value,
    output logic [ile_pkg::DATA_W-1:0] value,
    output logic [ile_pkg::DATA_W-1:0] rd_data
);
    import ile_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctl.ins) begin
            if (MY_IDX > tgt_pos) begin
                value_next = prev_value;
            end else if (MY_IDX == tgt_pos) begin
                value_next = ins_value;
            end
        end else if (ctl.del) begin
            if (MY_IDX >= tgt_pos) begin
                value_next = next_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value   = value_reg;
    assign rd_data = (MY_IDX == tgt_pos) ? value_reg : '0;

endmodule
`default_nettype wire

>>> rtl/core/indexed_list_engine.sv
// Top level: indexed ordered list built as a shifting chain of value cells.
//
//  channel  | ports                                   | dir
//  ---------+-----------------------------------------+-----
//  request  | s_valid s_ready s_func s_position       | in
//           | s_item_value                            |
//  result   | m_valid m_ready m_ok m_read_value       | out
//           | m_length                                |
//
// One request per cycle unless stalled: every cell shifts in parallel at the
// accept edge; the result lands in a single output register the cycle after.
// A read gathers the addressed cell through an OR across the chain.
// Reset (aresetn, sync, active low) clears the count and the output valid;
// cell contents stay undefined until written.
// s_ready drops only while a result waits and m_ready is low.
`default_nettype none
module indexed_list_engine #(
    parameter int CAPACITY = 64
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [ile_pkg::FUNC_W-1:0]   s_func,
    input  wire  [ile_pkg::POS_W-1:0]    s_position,
    input  wire  [ile_pkg::DATA_W-1:0]   s_item_value,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_ok,
    output logic [ile_pkg::DATA_W-1:0]   m_read_value,
    output logic [ile_pkg::LENGTH_W-1:0] m_length
);
    import ile_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_valid_reg;
    logic                m_ok_reg;
    logic                m_ok_next;
    logic [DATA_W-1:0]   m_read_value_reg;
    logic [DATA_W-1:0]   m_read_value_next;
    logic [LENGTH_W-1:0] m_length_reg;

    logic              s_fire;
    logic [CMP_W-1:0]  count_c;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  tgt_pos;
    logic              full;
    logic              ins_ok;
    logic              del_ok;
    logic              rd_hit;
    cell_ctl_t         ctl;
    logic [DATA_W-1:0] rd_or;

    logic [DATA_W-1:0] cell_val [CAPACITY];
    logic [DATA_W-1:0] cell_rd  [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign count_c = CMP_W'(count_reg);
    assign pos_c   = CMP_W'(s_position);
    assign full    = (count_c == CAP_C);

    always_comb begin
        tgt_pos           = pos_c;
        ins_ok            = 1'b0;
        del_ok            = 1'b0;
        rd_hit            = 1'b0;
        m_ok_next         = 1'b0;
        m_read_value_next = '0;
        case (op_t'(s_func))
            OP_READ: begin
                rd_hit            = (pos_c < count_c);
                m_ok_next         = rd_hit;
                m_read_value_next = rd_hit ? rd_or : '1;
            end
            OP_FRONT: begin
                tgt_pos   = '0;
                ins_ok    = !full;
                m_ok_next = ins_ok;
            end
            OP_APPEND: begin
                tgt_pos   = count_c;
                ins_ok    = !full;
                m_ok_next = ins_ok;
            end
            OP_INSERT: begin
                ins_ok    = !full && (pos_c <= count_c);
                m_ok_next = ins_ok;
            end
            OP_DELETE: begin
                del_ok    = (pos_c < count_c);
                m_ok_next = del_ok;
            end
            default: begin
                m_ok_next = 1'b0;
            end
        endcase
    end

    assign ctl.ins = s_fire && ins_ok;
    assign ctl.del = s_fire && del_ok;

    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + 1'b1;
        end else if (ctl.del) begin
            count_next = count_reg - 1'b1;
        end
    end

    // cell chain
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_W-1:0] prev_v;
        logic [DATA_W-1:0] next_v;
        if (k == 0) begin : g_first
            assign prev_v = '0;
        end else begin : g_mid_p
            assign prev_v = cell_val[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign next_v = '0;
        end else begin : g_mid_n
            assign next_v = cell_val[k+1];
        end
        ile_cell #(
            .IDX_W (CMP_W),
            .INDEX (k)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .tgt_pos    (tgt_pos),
            .ins_value  (s_item_value),
            .prev_value (prev_v),
            .next_value (next_v),
            .value      (cell_val[k]),
            .rd_data    (cell_rd[k])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_ok_reg         <= m_ok_next;
            m_read_value_reg <= m_read_value_next;
            m_length_reg     <= LENGTH_W'(count_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ok         = m_ok_reg;
    assign m_read_value = m_read_value_reg;
    assign m_length     = m_length_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CAP_C)
        else $error("count above capacity");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow count");

    a_del_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.del |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not shrink count");

    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_fire)
        else $error("beat taken while result stalled");

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for indexed_list_engine: a queue-based list predictor checked per beat.
module tb;
    import ile_pkg::*;

    localparam int LIST_CAP = 64;
    localparam int POS_MAX  = (1 << POS_W) - 1;
    localparam logic [FUNC_W-1:0] FUNC_UNDEF_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNDEF_HI = 3'd7;
    localparam logic [DATA_W-1:0] READ_MISS = '1;

    typedef struct packed {
        logic                ok;
        logic [DATA_W-1:0]   rd;
        logic [LENGTH_W-1:0] len;
    } list_reply_t;

    typedef enum int {RX_OPEN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func = '0;
    logic [POS_W-1:0]    s_position = '0;
    logic [DATA_W-1:0]   s_item_value = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_ok;
    logic [DATA_W-1:0]   m_read_value;
    logic [LENGTH_W-1:0] m_length;

    logic [DATA_W-1:0] list_model[$];
    list_reply_t       pending_replies[$];

    int err_count = 0;
    int beats_sent = 0;
    int results_checked = 0;
    int read_hits = 0;
    int read_misses = 0;
    int full_rejects = 0;
    int range_rejects = 0;
    int undef_ops = 0;
    int peak_len = 0;

    bit       tx_gaps = 1'b1;
    int       burst_left = 0;
    bit       rx_locked = 1'b0;
    rx_mode_t rx_mode = RX_OPEN;
    logic [31:0] rx_mask = '1;
    logic [7:0]  rx_tick = '0;

    indexed_list_engine #(.CAPACITY(LIST_CAP)) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_position   (s_position),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ok         (m_ok),
        .m_read_value (m_read_value),
        .m_length     (m_length)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    function automatic list_reply_t apply_request(input logic [FUNC_W-1:0] func,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [DATA_W-1:0] val);
        list_reply_t r;
        int n;
        int at;
        r = '0;
        n = list_model.size();
        at = -1;
        case (func)
            OP_READ: begin
                if (pos < n) begin
                    r.ok = 1'b1;
                    r.rd = list_model[pos];
                    read_hits++;
                end else begin
                    r.rd = READ_MISS;
                    read_misses++;
                end
            end
            OP_FRONT:  at = 0;
            OP_APPEND: at = n;
            OP_INSERT: at = pos;
            OP_DELETE: begin
                if (pos < n) begin
                    list_model.delete(pos);
                    r.ok = 1'b1;
                end else begin
                    range_rejects++;
                end
            end
            default: undef_ops++;
        endcase
        if (at >= 0) begin
            if (n >= LIST_CAP) begin
                full_rejects++;
            end else if (at > n) begin
                range_rejects++;
            end else begin
                list_model.insert(at, val);
                r.ok = 1'b1;
            end
        end
        if (list_model.size() > peak_len) peak_len = list_model.size();
        r.len = LENGTH_W'(list_model.size());
        return r;
    endfunction

    // mostly in-range positions, some anywhere in the field
    function automatic logic [POS_W-1:0] pick_position(input logic [FUNC_W-1:0] func);
        int n;
        n = list_model.size();
        if ($urandom_range(0, 9) < 2) return POS_W'($urandom_range(0, POS_MAX));
        if (func == OP_INSERT || func == OP_FRONT || func == OP_APPEND)
            return POS_W'($urandom_range(0, n));
        if (n == 0) return '0;
        return POS_W'($urandom_range(0, n - 1));
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        $display("mismatch at %0t, result %0d: %s got %h want %h",
                 $time, results_checked, what, got, want);
        err_count++;
    endtask

    task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val);
        int gap;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                repeat (gap) begin
                    @(negedge aclk);
                    s_valid <= 1'b0;
                end
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_func       <= func;
        s_position   <= pos;
        s_item_value <= val;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_replies.push_back(apply_request(func, pos, val));
        beats_sent++;
    endtask

    always @(negedge aclk) begin
        rx_tick <= rx_tick + 8'd1;
        if (rx_tick[5:0] == '0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
            rx_mask <= $urandom;
        end
        if (rx_locked) begin
            m_ready <= 1'b1;
        end else begin
            case (rx_mode)
                RX_OPEN:    m_ready <= 1'b1;
                RX_PATTERN: m_ready <= rx_mask[rx_tick[4:0]];
                default:    m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : check_results
        list_reply_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_replies.size() == 0) begin
                flag_mismatch("beat with nothing outstanding, read_value", m_read_value, 'x);
            end else begin
                want = pending_replies.pop_front();
                if (m_ok !== want.ok) flag_mismatch("ok", DATA_W'(m_ok), DATA_W'(want.ok));
                if (m_read_value !== want.rd) flag_mismatch("read_value", m_read_value, want.rd);
                if (m_length !== want.len)
                    flag_mismatch("length", DATA_W'(m_length), DATA_W'(want.len));
            end
            results_checked++;
        end
    end

    task automatic test_directed;
        int f;
        send_beat(OP_READ, '0, $urandom);
        send_beat(OP_READ, POS_W'(POS_MAX), $urandom);
        send_beat(OP_DELETE, '0, $urandom);
        send_beat(OP_INSERT, 7'd1, 32'h0bad_0001);
        send_beat(OP_INSERT, 7'd0, 32'h0000_0005);
        send_beat(OP_FRONT, 7'd127, 32'h8000_0000);
        send_beat(OP_APPEND, 7'd127, 32'h7fff_ffff);
        send_beat(OP_INSERT, 7'd3, 32'hffff_ffff);
        send_beat(OP_INSERT, 7'd1, 32'h0000_0000);
        for (int i = 0; i < 5; i++) send_beat(OP_READ, POS_W'(i), $urandom);
        send_beat(OP_READ, 7'd5, $urandom);
        send_beat(OP_DELETE, 7'd5, $urandom);
        send_beat(OP_DELETE, 7'd2, $urandom);
        send_beat(OP_DELETE, 7'd0, $urandom);
        for (f = FUNC_UNDEF_LO; f <= FUNC_UNDEF_HI; f++)
            send_beat(FUNC_W'(f), POS_W'($urandom), $urandom);
        send_beat(OP_READ, POS_W'(POS_MAX), $urandom);
        send_beat(OP_DELETE, POS_W'(POS_MAX), $urandom);
        send_beat(OP_INSERT, POS_W'(POS_MAX), $urandom);
    endtask

    task automatic test_fill_to_capacity;
        logic [FUNC_W-1:0] f;
        // back-to-back on both sides while filling
        tx_gaps = 1'b0;
        rx_locked = 1'b1;
        while (list_model.size() < LIST_CAP) begin
            case ($urandom_range(0, 2))
                0:       f = OP_FRONT;
                1:       f = OP_APPEND;
                default: f = OP_INSERT;
            endcase
            send_beat(f, pick_position(f), $urandom);
        end
        send_beat(OP_FRONT, '0, $urandom);
        send_beat(OP_APPEND, '0, $urandom);
        send_beat(OP_INSERT, '0, $urandom);
        send_beat(OP_INSERT, POS_W'(LIST_CAP), $urandom);
        send_beat(OP_READ, '0, $urandom);
        send_beat(OP_READ, POS_W'(LIST_CAP - 1), $urandom);
        send_beat(OP_READ, POS_W'(LIST_CAP), $urandom);
        send_beat(OP_DELETE, POS_W'(LIST_CAP), $urandom);
        send_beat(OP_DELETE, POS_W'(LIST_CAP - 1), $urandom);
        send_beat(OP_APPEND, '0, $urandom);
        tx_gaps = 1'b1;
        rx_locked = 1'b0;
        while (list_model.size() > 0) begin
            if ($urandom_range(0, 3) == 0) send_beat(OP_READ, pick_position(OP_READ), $urandom);
            send_beat(OP_DELETE, pick_position(OP_DELETE), $urandom);
        end
    endtask

    task automatic test_random_mix(input int n_items);
        int i;
        int bias;
        int thr;
        int r;
        logic [FUNC_W-1:0] f;
        bias = 2;
        for (i = 0; i < n_items; i++) begin
            // phases that grow, shrink or hold the list
            if (i % 96 == 0) bias = $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            if (r < 3) begin
                f = FUNC_W'($urandom_range(FUNC_UNDEF_LO, FUNC_UNDEF_HI));
            end else if (r < 25) begin
                f = OP_READ;
            end else begin
                case (bias)
                    0:       thr = 75;
                    1:       thr = 30;
                    default: thr = 52;
                endcase
                if ($urandom_range(0, 99) < thr) begin
                    case ($urandom_range(0, 2))
                        0:       f = OP_FRONT;
                        1:       f = OP_APPEND;
                        default: f = OP_INSERT;
                    endcase
                end else begin
                    f = OP_DELETE;
                end
            end
            send_beat(f, pick_position(f), $urandom);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_fill_to_capacity();
        test_random_mix(1700);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("covered %0d requests, %0d results checked, peak length %0d of %0d",
                 beats_sent, results_checked, peak_len, LIST_CAP);
        $display("read hits %0d, read misses %0d, full rejects %0d, range rejects %0d, %s %0d",
                 read_hits, read_misses, full_rejects, range_rejects, "undefined ops",
                 undef_ops);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/ile_pkg.sv
rtl/core/ile_cell.sv
rtl/core/indexed_list_engine.sv
tb/sv/tb.sv
